[hdl/tcw_pkg.sv]
// Shared types and constants of the text console character writer.
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int IDX_W     = 11;
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int ATTR_W    = 2 * COLOR_W;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h0F;
  localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BG   = 4'h0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_BLANK,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_data;
  } result_t;

endpackage

[hdl/tcw_in_if.sv]
// Command channel: operation, character and cell index.
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OP_W-1:0]     operation;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::IDX_W-1:0]    cell_index;

  modport source (output valid, operation, char_code, cell_index, input ready);
  modport sink   (input valid, operation, char_code, cell_index, output ready);
endinterface

[hdl/tcw_out_if.sv]
// Result channel: cursor index and cell data.
interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::IDX_W-1:0]    cursor_index;
  logic [tcw_pkg::CELL_W-1:0]   cell_data;

  modport source (output valid, cursor_index, cell_data, input ready);
  modport sink   (input valid, cursor_index, cell_data, output ready);
endinterface

[hdl/tcw_cell_mem.sv]
// Text cell memory: one write port, one read port, registered read data.
module tcw_cell_mem #(
  parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= cells[raddr];
  end

endmodule

[hdl/tcw_ctrl.sv]
// Cursor, scroll base and memory sequencer of the text console.
module tcw_ctrl #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF,
  parameter int ADDR_W    = $clog2(COLUMNS * ROWS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [tcw_pkg::OP_W-1:0]     operation,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr,
  input  logic                         out_free,
  output logic                         res_load,
  output tcw_pkg::result_t             res,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]   mem_wdata,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int TAB_W  = $clog2(TAB_WIDTH);
  localparam int CT_W   = ((COL_W > TAB_W) ? COL_W : TAB_W) + 2;
  localparam int WIDE_W = ADDR_W + tcw_pkg::IDX_W;

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W:0]   CELLS_X  = (ADDR_W + 1)'(CELLS);
  localparam logic [CT_W-1:0]   COLS_X   = CT_W'(COLUMNS);
  localparam logic [CT_W-1:0]   TAB_X    = CT_W'(TAB_WIDTH);
  localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [TAB_W-1:0]  PH_LAST  = TAB_W'(TAB_WIDTH - 1);
  localparam logic [COL_W-1:0]  CNT_LAST = COL_W'(COLUMNS - 1);
  localparam logic [WIDE_W-1:0] CELLS_W  = WIDE_W'(CELLS);

  tcw_pkg::state_t state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [TAB_W-1:0]  phase, phase_next;
  logic [ADDR_W-1:0] base, base_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [COL_W-1:0]  cnt, cnt_next;

  logic              accept;
  tcw_pkg::op_t      op;
  logic [CT_W-1:0]   col_t;
  logic [ROW_W:0]    row_t;
  logic [TAB_W-1:0]  ph_t;
  logic              printable;
  logic              scroll;
  logic [COL_W-1:0]  col_put;
  logic [ROW_W-1:0]  row_put;
  logic [WIDE_W-1:0] rd_wide;
  logic              rd_in;
  logic [ADDR_W-1:0] lin_cur;
  logic [ADDR_W-1:0] lin_put;
  logic [ADDR_W-1:0] addr_inc;

  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] a,
                                             input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CELLS_X) begin
      sum = sum - CELLS_X;
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [tcw_pkg::IDX_W-1:0] idx_of(input logic [ADDR_W-1:0] a);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(a);
    return w[tcw_pkg::IDX_W-1:0];
  endfunction

  assign cmd_ready = (state == tcw_pkg::ST_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign op        = tcw_pkg::op_t'(operation);
  assign rd_wide   = WIDE_W'(cell_index);
  assign rd_in     = rd_wide < CELLS_W;
  assign lin_cur   = ADDR_W'(row) * COLS_A + ADDR_W'(col);
  assign lin_put   = ADDR_W'(row_put) * COLS_A + ADDR_W'(col_put);
  assign addr_inc  = (addr == LAST_A) ? '0 : addr + 1'b1;

  // Cursor update for a put; phase tracks col modulo the tab width.
  always_comb begin
    col_t     = CT_W'(col);
    row_t     = {1'b0, row};
    ph_t      = phase;
    printable = 1'b0;
    priority if (char_code == tcw_pkg::CH_BS) begin
      if (col != '0) begin
        col_t = CT_W'(col) - 1'b1;
        ph_t  = (phase == '0) ? PH_LAST : phase - 1'b1;
      end
    end else if (char_code == tcw_pkg::CH_TAB) begin
      col_t = CT_W'(col) - CT_W'(phase) + TAB_X;
      ph_t  = '0;
    end else if (char_code == tcw_pkg::CH_CR) begin
      col_t = '0;
      ph_t  = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      col_t = '0;
      ph_t  = '0;
      row_t = {1'b0, row} + 1'b1;
    end else if (char_code >= tcw_pkg::CH_SPACE && char_code <= tcw_pkg::CH_DEL) begin
      printable = 1'b1;
      col_t     = CT_W'(col) + 1'b1;
      ph_t      = (phase == PH_LAST) ? '0 : phase + 1'b1;
    end else begin
      printable = 1'b0;
    end
    if (col_t >= COLS_X) begin
      col_t = '0;
      ph_t  = '0;
      row_t = row_t + 1'b1;
    end
    scroll  = row_t >= ROWS_X;
    col_put = col_t[COL_W-1:0];
    row_put = scroll ? ROW_LAST : row_t[ROW_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (addr == LAST_A) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tcw_pkg::OP_PUT: begin
              if (scroll) begin
                state_next = tcw_pkg::ST_BLANK;
              end
            end
            tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::OP_READ: begin
              if (rd_in) begin
                state_next = tcw_pkg::ST_READ;
              end
            end
            tcw_pkg::OP_NONE: state_next = tcw_pkg::ST_IDLE;
            default:          state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (addr == LAST_A) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_BLANK: begin
        if (cnt == CNT_LAST) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
      default:          state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    col_next         = col;
    row_next         = row;
    phase_next       = phase;
    base_next        = base;
    addr_next        = addr;
    cnt_next         = cnt;
    mem_we           = 1'b0;
    mem_waddr        = addr;
    mem_wdata        = {attr, tcw_pkg::CH_SPACE};
    mem_raddr        = phys(rd_wide[ADDR_W-1:0], base);
    res_load         = 1'b0;
    res.cursor_index = idx_of(lin_cur);
    res.cell_data    = '0;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
        addr_next = addr_inc;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tcw_pkg::OP_PUT: begin
              mem_we     = printable;
              mem_waddr  = phys(lin_cur, base);
              mem_wdata  = {attr, char_code};
              col_next   = col_put;
              row_next   = row_put;
              phase_next = ph_t;
              if (scroll) begin
                // old top row becomes the new bottom row
                base_next = phys(base, COLS_A);
                addr_next = base;
                cnt_next  = '0;
              end else begin
                res_load         = 1'b1;
                res.cursor_index = idx_of(lin_put);
              end
            end
            tcw_pkg::OP_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              phase_next = '0;
              base_next  = '0;
              addr_next  = '0;
            end
            tcw_pkg::OP_READ: begin
              res_load = !rd_in;
            end
            tcw_pkg::OP_NONE: res_load = 1'b1;
            default:          res_load = 1'b1;
          endcase
        end
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        addr_next = addr_inc;
        res_load  = addr == LAST_A;
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        addr_next = addr_inc;
        cnt_next  = cnt + 1'b1;
        res_load  = cnt == CNT_LAST;
      end
      tcw_pkg::ST_READ: begin
        res_load      = 1'b1;
        res.cell_data = mem_rdata;
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
      col   <= '0;
      row   <= '0;
      phase <= '0;
      base  <= '0;
      addr  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      phase <= phase_next;
      base  <= base_next;
      addr  <= addr_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hdl/text_console_char_writer.sv]
// Text console character writer: top level with config registers and result register.
//
// Commands arrive on cmd (operation, char_code, cell_index); each command gives
// exactly one item on rsp (cursor_index, cell_data). Config writes set the
// foreground and background colors through cfg_we / cfg_index / cfg_data.
// The cell store is a single memory addressed as a circular buffer of rows,
// so a scroll only moves a base pointer and blanks one row.
// From command to result register: a put without scroll loads the result
//   register directly; a put with scroll first blanks the new bottom row
//   (one memory write per blanked cell); a clear writes a blank to every
//   cell in turn, one write per cell; a read in range waits for the registered
//   memory read; other codes load the result register directly.
// One command is in progress at a time; cmd.ready is high when the sequencer
// is idle and the result register is empty or being emptied.
// After reset a clearing pass writes blank cells (attribute 0x0F) over the
// whole memory, one cell after another, with cmd.ready low.
// When rsp stalls the result is held and no new command is taken.
module text_console_char_writer #(
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tcw_in_if.sink                          cmd,
  tcw_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int WIDE_W = ADDR_W + tcw_pkg::IDX_W;

  logic [tcw_pkg::COLOR_W-1:0] fg;
  logic [tcw_pkg::COLOR_W-1:0] bg;
  logic                        out_valid;
  tcw_pkg::result_t            out_res;
  logic                        out_free;
  logic                        res_load;
  tcw_pkg::result_t            res;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::RESET_FG;
      bg <= tcw_pkg::RESET_BG;
    end else if (cfg_we) begin
      unique case (tcw_pkg::cfg_reg_t'(cfg_index))
        tcw_pkg::CFG_FG: fg <= cfg_data;
        tcw_pkg::CFG_BG: bg <= cfg_data;
        default:         fg <= fg;
      endcase
    end
  end

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.cursor_index = out_res.cursor_index;
  assign rsp.cell_data    = out_res.cell_data;

  tcw_ctrl #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .operation  (cmd.operation),
    .char_code  (cmd.char_code),
    .cell_index (cmd.cell_index),
    .attr       ({bg, fg}),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over a pending item");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (WIDE_W'(rsp.cursor_index) < WIDE_W'(CELLS)))
    else $error("cursor index out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.operation == tcw_pkg::OP_CLEAR) |=> !cmd.ready)
    else $error("command taken during clear");

endmodule
